// ===== src/b64c_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and alphabet functions of the base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

    // quartet padding status while decoding
    localparam logic [1:0] PAD_NONE  = 2'd0;
    localparam logic [1:0] PAD_THIRD = 2'd1;
    localparam logic [1:0] PAD_BAD   = 2'd2;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       has_data;
        logic       bad_input;
        logic       end_of_stream;
    } t_result;

    // all results caused by one input word; last_idx is result count minus one
    typedef struct packed {
        logic [1:0]    last_idx;
        t_result [3:0] res;
    } t_packet;

    typedef struct packed {
        logic    push;
        t_packet pkt;
    } t_push;

    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } t_sextet;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic t_sextet char_sextet(input logic [7:0] c);
        t_sextet s;
        s.bad = 1'b0;
        s.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.val = 6'd63;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== src/b64c_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64c channel interfaces
// Valid/ready channels for input words, result words and the direction write.
// ----------------------------------------------------------------------------
interface b64c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       is_last;
    modport source (output valid, symbol, is_last, input ready);
    modport sink   (input valid, symbol, is_last, output ready);
endinterface

interface b64c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       has_data;
    logic       bad_input;
    logic       end_of_stream;
    modport source (output valid, out_symbol, has_data, bad_input, end_of_stream,
                    input ready);
    modport sink   (input valid, out_symbol, has_data, bad_input, end_of_stream,
                    output ready);
endinterface

interface b64c_cfg_if;
    logic valid;
    logic ready;
    logic direction;
    modport source (output valid, direction, input ready);
    modport sink   (input valid, direction, output ready);
endinterface
`default_nettype wire

// ===== src/b64c_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input words, keeps the group state and builds one result packet
// per word that causes results.
// ----------------------------------------------------------------------------
module b64c_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    b64c_in_if.sink                i_in_ch,
    input  wire logic              i_direction,
    input  wire logic              i_q_full,
    output b64c_pkg::t_push        o_push
);

    logic [17:0] r_held, n_held;
    logic [1:0]  r_fill, n_fill;
    logic [1:0]  r_pad, n_pad;
    logic        r_skip, n_skip;

    logic                   w_accept;
    logic [2:0]             w_cnt;
    logic [1:0]             w_last_idx;
    b64c_pkg::t_result [3:0] w_res;
    b64c_pkg::t_sextet      w_sx;
    logic [7:0]             w_c;
    logic                   w_last;
    logic                   w_eq;
    logic                   w_bad;
    logic [1:0]             w_f;
    logic [7:0]             w_b0;
    logic [7:0]             w_b1;
    logic [5:0]             w_v;
    logic [5:0]             w_v3;

    assign i_in_ch.ready = !i_q_full;
    assign w_accept      = i_in_ch.valid && !i_q_full;
    assign w_c           = i_in_ch.symbol;
    assign w_last        = i_in_ch.is_last;
    assign w_sx          = b64c_pkg::char_sextet(w_c);
    assign w_eq          = (w_c == b64c_pkg::PAD_CHAR);
    assign w_f           = (r_fill > 2'd2) ? 2'd2 : r_fill;
    assign w_b0          = r_held[15:8];
    assign w_b1          = r_held[7:0];
    assign w_v3          = w_eq ? 6'd0 : w_sx.val;
    assign w_bad         = (r_pad == b64c_pkg::PAD_BAD)
                         || (r_pad == b64c_pkg::PAD_THIRD && !w_eq)
                         || (!w_eq && w_sx.bad);
    assign w_last_idx    = 2'(w_cnt - 3'd1);

    always_comb begin
        n_held = r_held;
        n_fill = r_fill;
        n_pad  = r_pad;
        n_skip = r_skip;
        w_cnt  = 3'd0;
        w_res  = '0;
        w_v    = 6'd0;
        if (r_skip) begin
            if (w_last) begin
                w_res[0].bad_input = 1'b1;
                w_cnt = 3'd1;
            end
        end else if (!i_direction) begin
            if (w_f == 2'd2) begin
                w_res[0].out_symbol = b64c_pkg::sextet_char(w_b0[7:2]);
                w_res[1].out_symbol = b64c_pkg::sextet_char({w_b0[1:0], w_b1[7:4]});
                w_res[2].out_symbol = b64c_pkg::sextet_char({w_b1[3:0], w_c[7:6]});
                w_res[3].out_symbol = b64c_pkg::sextet_char(w_c[5:0]);
                n_held = '0;
                n_fill = 2'd0;
                w_cnt  = 3'd4;
            end else begin
                n_held = {2'b00, w_b1, w_c};
                n_fill = w_f + 2'd1;
                if (w_last) begin
                    // flush the partial group with padding
                    if (w_f == 2'd0) begin
                        w_res[0].out_symbol = b64c_pkg::sextet_char(w_c[7:2]);
                        w_res[1].out_symbol = b64c_pkg::sextet_char({w_c[1:0], 4'b0000});
                        w_res[2].out_symbol = b64c_pkg::PAD_CHAR;
                    end else begin
                        w_res[0].out_symbol = b64c_pkg::sextet_char(w_b1[7:2]);
                        w_res[1].out_symbol = b64c_pkg::sextet_char({w_b1[1:0], w_c[7:4]});
                        w_res[2].out_symbol = b64c_pkg::sextet_char({w_c[3:0], 2'b00});
                    end
                    w_res[3].out_symbol = b64c_pkg::PAD_CHAR;
                    w_cnt = 3'd4;
                end
            end
            for (int i = 0; i < 4; i++) begin
                w_res[i].has_data = (3'(i) < w_cnt);
            end
        end else begin
            if (r_fill != 2'd3) begin
                w_v = w_sx.val;
                if (r_fill == 2'd2 && w_eq) begin
                    if (r_pad == b64c_pkg::PAD_NONE) begin
                        n_pad = b64c_pkg::PAD_THIRD;
                    end
                    w_v = 6'd0;
                end else if (w_sx.bad) begin
                    n_pad = b64c_pkg::PAD_BAD;
                    w_v   = 6'd0;
                end
                n_held = {r_held[11:0], w_v};
                n_fill = r_fill + 2'd1;
            end else begin
                n_held = '0;
                n_fill = 2'd0;
                n_pad  = b64c_pkg::PAD_NONE;
                if (w_bad) begin
                    w_res[0].bad_input = 1'b1;
                    n_skip = 1'b1;
                    w_cnt  = 3'd1;
                end else begin
                    w_res[0].out_symbol = {r_held[17:12], r_held[11:10]};
                    w_res[1].out_symbol = {r_held[9:6], r_held[5:2]};
                    w_res[2].out_symbol = {r_held[1:0], w_v3};
                    if (r_pad == b64c_pkg::PAD_THIRD) begin
                        w_cnt = 3'd1;
                    end else if (w_eq) begin
                        w_cnt = 3'd2;
                    end else begin
                        w_cnt = 3'd3;
                    end
                    for (int i = 0; i < 4; i++) begin
                        w_res[i].has_data = (3'(i) < w_cnt);
                    end
                end
            end
        end
        if (w_last) begin
            // close the stream: bare terminator when nothing else came out
            if (w_cnt == 3'd0) begin
                w_cnt = 3'd1;
            end
            for (int i = 0; i < 4; i++) begin
                if (2'(i) == 2'(w_cnt - 3'd1)) begin
                    w_res[i].end_of_stream = 1'b1;
                end
            end
            n_held = '0;
            n_fill = 2'd0;
            n_pad  = b64c_pkg::PAD_NONE;
            n_skip = 1'b0;
        end
    end

    assign o_push.push         = w_accept && (w_cnt != 3'd0);
    assign o_push.pkt.last_idx = w_last_idx;
    assign o_push.pkt.res      = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_fill <= 2'd0;
            r_pad  <= b64c_pkg::PAD_NONE;
            r_skip <= 1'b0;
        end else if (w_accept) begin
            r_held <= n_held;
            r_fill <= n_fill;
            r_pad  <= n_pad;
            r_skip <= n_skip;
        end
    end

endmodule
`default_nettype wire

// ===== src/b64c_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64c_queue
// Short packet queue between the front and the back end.
// ----------------------------------------------------------------------------
module b64c_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire b64c_pkg::t_push   i_push,
    output logic                   o_full,
    output logic                   o_valid,
    output b64c_pkg::t_packet      o_pkt,
    input  wire logic              i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64c_pkg::t_packet r_mem [DEPTH];
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_pkt   = r_mem[r_rd];
    assign w_wr    = i_push.push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_push.pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= n_wr;
            end
            if (w_rd) begin
                r_rd <= n_rd;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/b64c_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64c_back
// Takes queue packets, sends their results one word a cycle while output is ready.
// ----------------------------------------------------------------------------
module b64c_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire b64c_pkg::t_packet i_q_pkt,
    output logic                   o_pop,
    b64c_out_if.source             o_out_ch
);

    b64c_pkg::t_packet r_pkt;
    logic [1:0]        r_idx;
    logic              r_busy;
    logic              w_fire;
    logic              w_done;
    b64c_pkg::t_result w_cur;

    assign w_cur  = r_pkt.res[r_idx];
    assign w_fire = r_busy && o_out_ch.ready;
    assign w_done = w_fire && (r_idx == r_pkt.last_idx);
    // refill as the last result of the packet leaves, so words follow without a gap
    assign o_pop  = i_q_valid && (!r_busy || w_done);

    assign o_out_ch.valid         = r_busy;
    assign o_out_ch.out_symbol    = w_cur.out_symbol;
    assign o_out_ch.has_data      = w_cur.has_data;
    assign o_out_ch.bad_input     = w_cur.bad_input;
    assign o_out_ch.end_of_stream = w_cur.end_of_stream;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pkt <= i_q_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (w_fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule
`default_nettype wire

// ===== src/base64_stream_codec_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Streaming base64 encoder/decoder with '=' padding and error reporting.
// ----------------------------------------------------------------------------
// The direction register selects encode (0) or decode (1); write it only while
// the block is idle. The front end takes one input word per clock as long as
// the packet queue (QUEUE_DEPTH entries) has room, and turns each word into a
// packet of zero to four results. The back end sends one result word per clock
// while the receiver is ready. Encoding is bound by that result port, as every
// three bytes yield four results. Decoding yields at most three results per four
// characters, so while the receiver is ready it runs at the input rate of one
// character per clock. A packet is registered in the packet queue and then in
// the back end's packet register before its first result is presented.
module base64_stream_codec_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    b64c_in_if.sink     i_in_ch,
    b64c_out_if.source  o_out_ch,
    b64c_cfg_if.sink    i_cfg_ch
);

    logic                r_direction;
    b64c_pkg::t_push     w_push;
    logic                w_q_full;
    logic                w_q_valid;
    b64c_pkg::t_packet   w_q_pkt;
    logic                w_pop;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_ch.valid) begin
            r_direction <= i_cfg_ch.direction;
        end
    end

    b64c_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (i_in_ch),
        .i_direction (r_direction),
        .i_q_full    (w_q_full),
        .o_push      (w_push)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_pkt   (w_q_pkt),
        .i_pop   (w_pop)
    );

    b64c_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_pkt   (w_q_pkt),
        .o_pop     (w_pop),
        .o_out_ch  (o_out_ch)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |-> !w_q_full)
        else $error("packet pushed into a full queue");

    a_data_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> !(o_out_ch.has_data && o_out_ch.bad_input))
        else $error("result marked both data and error");

    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && !o_out_ch.has_data && !o_out_ch.bad_input)
            |-> o_out_ch.end_of_stream)
        else $error("bare result that does not close the stream");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from an empty queue");

endmodule
`default_nettype wire
